FILE: rtl/icmap_pkg.sv
package icmap_pkg;

  localparam int FRAC_BITS = 8;
  localparam int NORM_BITS = 16;

  localparam int INT_W   = 29;
  localparam int DIFF_W  = INT_W + 1;
  localparam int T_W     = NORM_BITS + 1;
  localparam int S_W     = NORM_BITS + 3;
  localparam int PROD_W  = T_W + 8;
  localparam int CNT_W   = $clog2(NORM_BITS);
  localparam int CH_W    = 8;
  localparam int COLOR_W = 3 * CH_W;
  localparam int LABEL_W = 16;
  localparam int MODE_W  = 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;

  localparam int MODE_RAINBOW = 0;
  localparam int MODE_INVERT  = 1;
  localparam int MODE_AUTO    = 2;
  localparam int MODE_FILTER  = 3;

  localparam logic signed [INT_W-1:0] BOUND_LIM = INT_W'(longint'(999999) << FRAC_BITS);
  localparam logic signed [INT_W-1:0] NEG_LIM   = -BOUND_LIM;
  localparam logic signed [INT_W-1:0] DEF_HIGH  = INT_W'(longint'(4096) << FRAC_BITS);

  localparam logic [T_W-1:0]    Q_ONE  = {1'b1, {NORM_BITS{1'b0}}};
  localparam logic [PROD_W-1:0] Q_HALF = PROD_W'(1) << (NORM_BITS - 1);

  localparam logic [MODE_W-1:0]  MODE_RST     = 4'd5;
  localparam logic [COLOR_W-1:0] HI_COLOR_RST = {COLOR_W{1'b1}};

  typedef enum logic [2:0] {
    REG_MODE,
    REG_MIN_BOUND,
    REG_MAX_BOUND,
    REG_LO_COLOR,
    REG_HI_COLOR,
    REG_FILTER
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_COLOR
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [INT_W-1:0]  min_bound;
    logic signed [INT_W-1:0]  max_bound;
    logic [COLOR_W-1:0]       lo_color;
    logic [COLOR_W-1:0]       hi_color;
    logic [LABEL_W-1:0]       filter_label;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic gather;
    logic setup;
    logic div_step;
    logic color;
  } cmd_t;

endpackage

FILE: rtl/icmap_regs.sv
module icmap_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [icmap_pkg::ADDR_W-1:0]  paddr,
  input  logic [icmap_pkg::DATA_W-1:0]  pwdata,
  output logic [icmap_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output icmap_pkg::cfg_t               cfg
);
  import icmap_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_RST;
      cfg.min_bound    <= '0;
      cfg.max_bound    <= DEF_HIGH;
      cfg.lo_color     <= '0;
      cfg.hi_color     <= HI_COLOR_RST;
      cfg.filter_label <= '0;
    end else if (wr) begin
      case (idx)
        REG_MODE:      cfg.mode         <= pwdata[MODE_W-1:0];
        REG_MIN_BOUND: cfg.min_bound    <= pwdata[INT_W-1:0];
        REG_MAX_BOUND: cfg.max_bound    <= pwdata[INT_W-1:0];
        REG_LO_COLOR:  cfg.lo_color     <= pwdata[COLOR_W-1:0];
        REG_HI_COLOR:  cfg.hi_color     <= pwdata[COLOR_W-1:0];
        REG_FILTER:    cfg.filter_label <= pwdata[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:      prdata = DATA_W'(cfg.mode);
      REG_MIN_BOUND: prdata = DATA_W'(cfg.min_bound);
      REG_MAX_BOUND: prdata = DATA_W'(cfg.max_bound);
      REG_LO_COLOR:  prdata = DATA_W'(cfg.lo_color);
      REG_HI_COLOR:  prdata = DATA_W'(cfg.hi_color);
      REG_FILTER:    prdata = DATA_W'(cfg.filter_label);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/icmap_ctrl.sv
module icmap_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            operation,
  input  logic            out_stall,
  output logic            in_stall,
  output logic            out_valid,
  output icmap_pkg::cmd_t cmd
);
  import icmap_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (operation) begin
            cmd.capture = 1'b1;
            state_next  = ST_SETUP;
          end else begin
            cmd.gather = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(NORM_BITS - 1)) begin
          state_next = ST_COLOR;
        end
      end
      ST_COLOR: begin
        if (!out_valid || !out_stall) begin
          cmd.color      = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/icmap_dp.sv
module icmap_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  icmap_pkg::cmd_t                       cmd,
  input  icmap_pkg::cfg_t                       cfg,
  input  logic signed [icmap_pkg::INT_W-1:0]    intensity,
  input  logic [icmap_pkg::LABEL_W-1:0]         label,
  input  logic                                  last_point,
  output logic [icmap_pkg::CH_W-1:0]            red,
  output logic [icmap_pkg::CH_W-1:0]            green,
  output logic [icmap_pkg::CH_W-1:0]            blue,
  output logic                                  visible,
  output logic                                  end_of_cloud
);
  import icmap_pkg::*;

  function automatic logic [CH_W-1:0] to_chan(input logic [T_W-1:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(255) + Q_HALF;
    return p[NORM_BITS+CH_W-1:NORM_BITS];
  endfunction

  function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] mc,
                                            input logic [CH_W-1:0] nc,
                                            input logic [T_W-1:0]  tt,
                                            input logic [T_W-1:0]  uu);
    logic [PROD_W-1:0] p;
    p = PROD_W'(mc) * PROD_W'(tt) + PROD_W'(nc) * PROD_W'(uu) + Q_HALF;
    return p[NORM_BITS+CH_W-1:NORM_BITS];
  endfunction

  // bounds trackers
  logic signed [INT_W-1:0] running_low;
  logic signed [INT_W-1:0] running_high;
  logic signed [INT_W-1:0] latched_low;
  logic signed [INT_W-1:0] latched_high;
  logic signed [INT_W-1:0] low_upd;
  logic signed [INT_W-1:0] high_upd;
  logic                    match_in;

  // captured item and divider
  logic signed [INT_W-1:0] val_q;
  logic                    match_q;
  logic                    last_q;
  logic [INT_W-1:0]        rem;
  logic [INT_W-1:0]        dvs;
  logic [NORM_BITS-1:0]    quo;
  logic                    sp_zero;
  logic                    sp_one;

  logic signed [INT_W-1:0]  low_sel;
  logic signed [INT_W-1:0]  high_sel;
  logic signed [DIFF_W-1:0] num;
  logic signed [DIFF_W-1:0] span;
  logic signed [DIFF_W-1:0] num_abs;
  logic signed [DIFF_W-1:0] span_abs;
  logic [DIFF_W-1:0]        trial;
  logic [DIFF_W-1:0]        diff;
  logic                     ge;

  // color
  logic [T_W-1:0]       t;
  logic [T_W-1:0]       u;
  logic [T_W-1:0]       v;
  logic [S_W-1:0]       s;
  logic [2:0]           seg;
  logic [T_W-1:0]       n;
  logic [CH_W-1:0]      nch;
  logic [CH_W-1:0]      red_next;
  logic [CH_W-1:0]      green_next;
  logic [CH_W-1:0]      blue_next;

  assign match_in = !cfg.mode[MODE_FILTER] || (label == cfg.filter_label);
  assign low_upd  = (match_in && (intensity < running_low))  ? intensity : running_low;
  assign high_upd = (match_in && (intensity > running_high)) ? intensity : running_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_low  <= BOUND_LIM;
      running_high <= NEG_LIM;
      latched_low  <= '0;
      latched_high <= DEF_HIGH;
    end else if (cmd.gather) begin
      if (last_point) begin
        latched_low  <= (low_upd < NEG_LIM) ? NEG_LIM : low_upd;
        latched_high <= (high_upd > BOUND_LIM) ? BOUND_LIM : high_upd;
        running_low  <= BOUND_LIM;
        running_high <= NEG_LIM;
      end else begin
        running_low  <= low_upd;
        running_high <= high_upd;
      end
    end
  end

  always_comb begin
    low_sel  = cfg.mode[MODE_AUTO] ? latched_low  : cfg.min_bound;
    high_sel = cfg.mode[MODE_AUTO] ? latched_high : cfg.max_bound;
    num      = DIFF_W'(val_q) - DIFF_W'(low_sel);
    span     = DIFF_W'(high_sel) - DIFF_W'(low_sel);
    num_abs  = num[DIFF_W-1]  ? -num  : num;
    span_abs = span[DIFF_W-1] ? -span : span;
    trial    = {rem, 1'b0};
    ge       = trial >= {1'b0, dvs};
    diff     = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_q   <= intensity;
      match_q <= match_in;
      last_q  <= last_point;
    end
    if (cmd.setup) begin
      rem     <= num_abs[INT_W-1:0];
      dvs     <= span_abs[INT_W-1:0];
      quo     <= '0;
      sp_zero <= (span == '0) || (num == '0) || (num[DIFF_W-1] != span[DIFF_W-1]);
      sp_one  <= num_abs[INT_W-1:0] >= span_abs[INT_W-1:0];
    end
    if (cmd.div_step) begin
      rem <= ge ? diff[INT_W-1:0] : trial[INT_W-1:0];
      quo <= {quo[NORM_BITS-2:0], ge};
    end
  end

  always_comb begin
    t   = sp_zero ? '0 : (sp_one ? Q_ONE : {1'b0, quo});
    u   = Q_ONE - t;
    v   = cfg.mode[MODE_INVERT] ? t : u;
    s   = (S_W'(v) << 2) + S_W'(v);
    seg = s[S_W-1:NORM_BITS];
    n   = seg[0] ? {1'b0, s[NORM_BITS-1:0]} : (Q_ONE - {1'b0, s[NORM_BITS-1:0]});
    nch = to_chan(n);
    if (cfg.mode[MODE_RAINBOW]) begin
      case (seg)
        3'd0: begin
          red_next = nch;  green_next = '0;   blue_next = '1;
        end
        3'd1: begin
          red_next = '0;   green_next = nch;  blue_next = '1;
        end
        3'd2: begin
          red_next = '0;   green_next = '1;   blue_next = nch;
        end
        3'd3: begin
          red_next = nch;  green_next = '1;   blue_next = '0;
        end
        default: begin
          red_next = '1;   green_next = nch;  blue_next = '0;
        end
      endcase
    end else begin
      red_next   = blend(cfg.hi_color[3*CH_W-1:2*CH_W], cfg.lo_color[3*CH_W-1:2*CH_W], t, u);
      green_next = blend(cfg.hi_color[2*CH_W-1:CH_W], cfg.lo_color[2*CH_W-1:CH_W], t, u);
      blue_next  = blend(cfg.hi_color[CH_W-1:0], cfg.lo_color[CH_W-1:0], t, u);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.color) begin
      red          <= red_next;
      green        <= green_next;
      blue         <= blue_next;
      visible      <= match_q;
      end_of_cloud <= last_q;
    end
  end

endmodule

FILE: rtl/intensity_colormap.sv
// intensity colormap: colors point intensities as a rainbow or a two-color blend
//
// input channel (in_valid / in_stall): operation, intensity, label, last_point.
// an item is taken at a clock edge with in_valid high and in_stall low.
// a gather item (operation 0) leaves in_stall low and gives no result; it
// updates the running min and max, and on last_point latches them and restarts.
// a colorize item (operation 1) gives one result on the output channel
// (out_valid / out_stall) through a setup step, the radix-2 span divider steps
// (one quotient bit a cycle) and a color step. in_stall stays high meanwhile and
// the next item is taken in the cycle after the color step, so no colorize item
// is taken before the previous one has reached its color step.
// the result sits in an output register; while out_stall holds it, the next
// item is still taken and worked on, and only its color step waits.
// configuration goes through the apb port, register i at byte address 4*i. The
// user must write it only while the block is idle; it is not enforced here.
// rst (synchronous) restores register defaults, clears the trackers and
// empties the output register.
module intensity_colormap (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [icmap_pkg::ADDR_W-1:0]         paddr,
  input  logic [icmap_pkg::DATA_W-1:0]         pwdata,
  output logic [icmap_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 operation,
  input  logic signed [icmap_pkg::INT_W-1:0]   intensity,
  input  logic [icmap_pkg::LABEL_W-1:0]        label,
  input  logic                                 last_point,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [icmap_pkg::CH_W-1:0]           red,
  output logic [icmap_pkg::CH_W-1:0]           green,
  output logic [icmap_pkg::CH_W-1:0]           blue,
  output logic                                 visible,
  output logic                                 end_of_cloud
);
  import icmap_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  icmap_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  icmap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  icmap_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .intensity    (intensity),
    .label        (label),
    .last_point   (last_point),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .visible      (visible),
    .end_of_cloud (end_of_cloud)
  );

  a_colorize_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation |=> in_stall)
    else $error("colorize item did not make the block busy");

  a_gather_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !operation |=> !in_stall)
    else $error("gather item held the input channel");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.color))
    else $error("result appeared without a color step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.color |-> !(out_valid && out_stall))
    else $error("color step overwrote a held result");

endmodule
